/* rtl/centered_moving_average_edges_defines.svh */
// Assertion macros for the centered moving average block.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef CENTERED_MOVING_AVERAGE_EDGES_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_EDGES_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CMAE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CMAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cmae_pkg.sv */
// Shared types and constants of the centered moving average block.
// No dependencies; used by the top level for port types and field widths.
package cmae_pkg;

	// defaults for the top-level parameters
	localparam int MAX_WINDOW_DEF  = 31;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths of the transactions and the register
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 16;
	localparam int WIN_W    = 5;

	localparam logic [WIN_W-1:0] WIN_RESET = 5'd5;
	localparam logic [IDX_W-1:0] COUNT_MAX = 16'hFFFF;

	// input transaction
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_sample;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic [SAMPLE_W-1:0] smoothed;
		logic [IDX_W-1:0]    out_index;
		logic                frame_done;
		logic                short_frame;
	} out_item_t;

endpackage

/* rtl/cmae_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Stand-alone; instantiated by the centered moving average top level.
module cmae_div #(
	parameter int DVD_W = 21,
	parameter int DVS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   shifted;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;

	// one restoring step: bring down the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		rem_nx  = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/centered_moving_average_edges.sv */
// Top level of the centered moving average with shrinking edge windows.
// Depends on cmae_pkg, cmae_div and centered_moving_average_edges_defines.svh.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   in       | to block  | in_valid/in_stall  | in_data (sample, last mark)
//   out      | from block| out_valid/out_stall| out_data (average, index)
//   cfg      | to block  | cfg_we             | cfg_wdata (window length)
//
// An item sums its window from the sample ring (one read a cycle), then takes
// one pass of the shared divider per result, none for a short frame's result;
// the last sample of a frame also flushes the tail results, one pass each.
// Reset is asynchronous; no clearing pass, the fill count masks stale samples.
// A stalled output holds its result in the output register; input is taken
// again as soon as the last result of an item sits in that register.
`include "centered_moving_average_edges_defines.svh"

module centered_moving_average_edges #(
	parameter int MAX_WINDOW  = cmae_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = cmae_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cmae_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cmae_pkg::out_item_t          out_data,
	input  logic                         cfg_we,
	input  logic [cmae_pkg::WIN_W-1:0]   cfg_wdata
);

	localparam int WIN_W     = cmae_pkg::WIN_W;
	localparam int IDX_W     = cmae_pkg::IDX_W;
	localparam int SMP_W     = (SAMPLE_BITS < cmae_pkg::SAMPLE_W) ? SAMPLE_BITS
	                                                            : cmae_pkg::SAMPLE_W;
	localparam int SUM_W     = SMP_W + $clog2(MAX_WINDOW + 1);
	localparam int PTR_W     = $clog2(MAX_WINDOW);
	localparam int PTR_X     = PTR_W + 1;
	localparam int PFX_DEPTH = (MAX_WINDOW + 1) / 2;
	localparam int PFX_AW    = $clog2(PFX_DEPTH);
	localparam int WX        = WIN_W + 1;
	localparam int WIN_MAXV  = (1 << WIN_W) - 1;
	localparam logic [WIN_W-1:0] WIN_LIM =
		WIN_W'((MAX_WINDOW < WIN_MAXV) ? MAX_WINDOW : WIN_MAXV);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SUM    = 4'd1;
	localparam logic [3:0] S_PRE    = 4'd2;
	localparam logic [3:0] S_PDIV   = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_EMIT   = 4'd5;
	localparam logic [3:0] S_TSTART = 4'd6;
	localparam logic [3:0] S_TRD0   = 4'd7;
	localparam logic [3:0] S_TRD1   = 4'd8;
	localparam logic [3:0] S_TRD2   = 4'd9;

	// control state
	logic [3:0]       state_q;
	logic [WIN_W-1:0] win_q;
	logic [IDX_W-1:0] cnt_q;
	logic [PTR_W-1:0] head_q;
	logic             tail_q;
	logic [WIN_W-1:0] iss_q;
	logic             acc_vld_s1;
	logic             out_valid_q;

	// item and result registers
	logic [IDX_W-1:0]          idx_q;
	logic                      last_q;
	logic [WIN_W-1:0]          w_q;
	logic [SUM_W-1:0]          acc_q;
	logic [SUM_W-1:0]          tsum_q;
	logic [WIN_W-1:0]          age_s1;
	logic [WIN_W-2:0]          j_q;
	logic [PFX_AW-1:0]         m_q;
	logic [cmae_pkg::SAMPLE_W-1:0] res_val_q;
	logic [IDX_W-1:0]          res_idx_q;
	logic                      res_done_q;
	logic                      res_short_q;
	cmae_pkg::out_item_t       out_q;

	// memories and their read data
	logic [SMP_W-1:0] smp_mem [MAX_WINDOW];
	logic [SUM_W-1:0] pfx_mem [PFX_DEPTH];
	logic [SMP_W-1:0] smp_rd_q;
	logic [SUM_W-1:0] pfx_rd_q;

	// combinational
	logic             in_acc;
	logic             out_load;
	logic [WIN_W-1:0] win_clamp;
	logic [WIN_W-1:0] eff_w;
	logic [PTR_W-1:0] head_nx;
	logic [IDX_W-1:0] cnt_nx;
	logic [WIN_W-2:0] lr;
	logic [WIN_W-1:0] w_m1;
	logic [WIN_W-2:0] j_m1;
	logic [IDX_W-1:0] idx_lr;
	logic             is_short;
	logic             is_interior;
	logic             emit_main;
	logic             rd_en;
	logic [WIN_W-1:0] rd_age;
	logic [SUM_W-1:0] acc_add;
	logic             tail_hit;
	logic [SUM_W-1:0] tsum_sub;
	logic             pfx_we;
	logic             pfx_re;
	logic             div_start;
	logic [SUM_W-1:0] div_dvd;
	logic [WIN_W-1:0] div_dvs;
	logic             div_done;
	logic [SUM_W-1:0] div_quo;

	// ring address of the sample that is age entries older than the newest
	function automatic logic [PTR_W-1:0] age_addr(input logic [PTR_W-1:0] head,
	                                               input logic [WIN_W-1:0] age);
		logic [PTR_X-1:0] h;
		logic [PTR_X-1:0] a;
		h = {1'b0, head};
		a = PTR_X'(age);
		if (h >= a) begin
			return PTR_W'(h - a);
		end
		return PTR_W'(h + PTR_X'(MAX_WINDOW) - a);
	endfunction

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// effective odd window from the register
	always_comb begin
		win_clamp = (win_q > WIN_LIM) ? WIN_LIM : win_q;
		if (win_clamp[0]) begin
			eff_w = win_clamp;
		end else if (win_clamp == '0) begin
			eff_w = WIN_W'(1);
		end else begin
			eff_w = win_clamp - WIN_W'(1);
		end
	end

	// ring pointer, fill count and per-item decisions
	always_comb begin
		head_nx     = (head_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : head_q + PTR_W'(1);
		cnt_nx      = (cnt_q == cmae_pkg::COUNT_MAX) ? cnt_q : cnt_q + IDX_W'(1);
		lr          = w_q[WIN_W-1:1];
		w_m1        = w_q - WIN_W'(1);
		j_m1        = j_q - (WIN_W-1)'(1);
		idx_lr      = idx_q - IDX_W'(lr);
		is_short    = last_q && (idx_q < IDX_W'(w_m1));
		is_interior = !(idx_q < IDX_W'(w_m1));
		emit_main   = idx_q >= IDX_W'(lr);
	end

	// sample ring read port select
	always_comb begin
		rd_en  = 1'b0;
		rd_age = iss_q;
		unique case (state_q)
			S_SUM: begin
				rd_en  = iss_q < w_q;
				rd_age = iss_q;
			end
			S_TRD0: begin
				rd_en  = 1'b1;
				rd_age = {j_m1, 1'b0};
			end
			S_TRD1: begin
				rd_en  = 1'b1;
				rd_age = {j_m1, 1'b0} - WIN_W'(1);
			end
			default: begin
				rd_en  = 1'b0;
				rd_age = iss_q;
			end
		endcase
	end

	// window accumulation; samples beyond the fill count read as zero
	// the first tail sum covers the newest W-2 samples
	always_comb begin
		acc_add  = acc_q + ((IDX_W'(age_s1) < cnt_q) ? SUM_W'(smp_rd_q) : '0);
		tail_hit = acc_vld_s1 && (WX'(age_s1) + WX'(3) == WX'(w_q));
		tsum_sub = tsum_q - SUM_W'(smp_rd_q);
	end

	// prefix store access; the read address always lies below the one written
	always_comb begin
		pfx_we = (state_q == S_PRE) && (idx_q < IDX_W'(w_q)) && !idx_q[0] &&
		         ((idx_q >> 1) < IDX_W'(PFX_DEPTH));
		pfx_re = (state_q == S_PRE) && !is_short && emit_main && !is_interior;
	end

	// divider launch select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = acc_q;
		div_dvs   = w_q;
		unique case (state_q)
			S_PRE: begin
				div_start = !is_short && emit_main && is_interior;
				div_dvd   = acc_q;
				div_dvs   = w_q;
			end
			S_PDIV: begin
				div_start = 1'b1;
				div_dvd   = pfx_rd_q;
				div_dvs   = WIN_W'({m_q, 1'b1});
			end
			S_TSTART: begin
				div_start = 1'b1;
				div_dvd   = tsum_q;
				div_dvs   = {j_m1, 1'b1};
			end
			default: begin
				div_start = 1'b0;
				div_dvd   = acc_q;
				div_dvs   = w_q;
			end
		endcase
	end

	cmae_div #(
		.DVD_W (SUM_W),
		.DVS_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sample ring: written on accept, one registered read a cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_mem[head_nx] <= in_data.sample[SMP_W-1:0];
		end
		if (rd_en) begin
			smp_rd_q <= smp_mem[age_addr(head_q, rd_age)];
		end
	end

	// prefix sums of the frame start
	always_ff @(posedge clk) begin
		if (pfx_we) begin
			pfx_mem[idx_q[PFX_AW:1]] <= acc_q;
		end
		if (pfx_re) begin
			pfx_rd_q <= pfx_mem[idx_lr[PFX_AW-1:0]];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= cmae_pkg::WIN_RESET;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= 1'b0;
			iss_q       <= '0;
			acc_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			acc_vld_s1 <= (state_q == S_SUM) && rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= cnt_nx;
						head_q  <= head_nx;
						tail_q  <= 1'b0;
						iss_q   <= '0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (rd_en) begin
						iss_q <= iss_q + WIN_W'(1);
					end else if (!acc_vld_s1) begin
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					if (is_short) begin
						state_q <= S_EMIT;
					end else if (emit_main) begin
						state_q <= is_interior ? S_DIV : S_PDIV;
					end else begin
						if (last_q) begin
							cnt_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_PDIV: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (res_done_q) begin
							cnt_q   <= '0;
							tail_q  <= 1'b0;
							state_q <= S_IDLE;
						end else if (tail_q) begin
							state_q <= S_TRD0;
						end else if (last_q) begin
							tail_q  <= 1'b1;
							state_q <= S_TSTART;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_TSTART: begin
					state_q <= S_DIV;
				end
				S_TRD0: begin
					state_q <= S_TRD1;
				end
				S_TRD1: begin
					state_q <= S_TRD2;
				end
				S_TRD2: begin
					state_q <= S_TSTART;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item, sum and result registers
	always_ff @(posedge clk) begin
		age_s1 <= iss_q;
		if (acc_vld_s1) begin
			acc_q <= acc_add;
			if (tail_hit) begin
				tsum_q <= acc_add;
			end
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					idx_q  <= cnt_q;
					last_q <= in_data.last_sample;
					w_q    <= eff_w;
					acc_q  <= '0;
				end
			end
			S_PRE: begin
				m_q <= idx_lr[PFX_AW-1:0];
				if (is_short) begin
					res_val_q   <= '0;
					res_idx_q   <= '0;
					res_done_q  <= 1'b1;
					res_short_q <= 1'b1;
				end else begin
					res_idx_q   <= idx_lr;
					res_done_q  <= last_q && (lr == '0);
					res_short_q <= 1'b0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_val_q <= cmae_pkg::SAMPLE_W'(div_quo);
				end
			end
			S_EMIT: begin
				if (out_load) begin
					out_q.smoothed    <= res_val_q;
					out_q.out_index   <= res_idx_q;
					out_q.frame_done  <= res_done_q;
					out_q.short_frame <= res_short_q;
					if (!res_done_q && !tail_q && last_q) begin
						j_q <= lr;
					end
				end
			end
			S_TSTART: begin
				res_idx_q   <= idx_q - IDX_W'(j_m1);
				res_done_q  <= (j_q == (WIN_W-1)'(1));
				res_short_q <= 1'b0;
			end
			S_TRD1: begin
				tsum_q <= tsum_sub;
			end
			S_TRD2: begin
				tsum_q <= tsum_sub;
				j_q    <= j_m1;
			end
			default: begin
			end
		endcase
	end

	// checks on the sequencer
	`CMAE_ASSERT_NEXT(a_accept_sums, clk, arst_n, in_acc, state_q == S_SUM, "accepted transaction did not start the window sum")
	`CMAE_ASSERT_IMPLY(a_div_done_waits, clk, arst_n, div_done, state_q == S_DIV, "divider finished outside the wait state")
	`CMAE_ASSERT_NEXT(a_frame_end_clears, clk, arst_n, out_load && res_done_q, cnt_q == '0 && state_q == S_IDLE, "frame end did not clear the fill count")
	`CMAE_ASSERT_IMPLY(a_short_is_final, clk, arst_n, out_valid_q && out_q.short_frame, out_q.frame_done && out_q.smoothed == '0, "short frame result malformed")
	`CMAE_ASSERT_IMPLY(a_tail_count, clk, arst_n, tail_q && state_q != S_IDLE, j_q != '0, "tail flush ran past its last output")

endmodule
